### hdl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### hdl/frp_pkg.sv
// Types, constants and the CRC-16/ARC byte update for the framed packet receiver.
// No dependencies.
package frp_pkg;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  localparam logic [7:0] RST_SYNC_FIRST  = 8'd170;
  localparam logic [7:0] RST_SYNC_SECOND = 8'd85;
  localparam logic [7:0] RST_VERSION     = 8'd1;
  localparam logic [7:0] RST_MAX_PAYLOAD = 8'd64;

  localparam int unsigned PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_VERSION     = 2'd2,
    REG_MAX_PAYLOAD = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_BODY      = 3'd0,
    ST_OK        = 3'd1,
    ST_CRC_FAIL  = 3'd2,
    ST_BAD_VER   = 3'd3,
    ST_LEN_OVF   = 3'd4,
    ST_SYNC_MISS = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] protocol_version;
    logic [7:0] max_payload;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  data_byte;
    logic [7:0]  frame_flags;
    logic [15:0] frame_cmd;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_len;
  } result_t;

  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/frp_parser.sv
// Frame parser state machine: sync hunt, header capture, body pass-through, CRC check.
// Depends on frp_pkg.
module frp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  frp_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  output frp_pkg::result_t res_o
);
  import frp_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC1  = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_HEADER = 3'd2,
    PH_BODY   = 3'd3,
    PH_CRC    = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  body_q, body_d;
  logic        crc_pos_q, crc_pos_d;
  logic [7:0]  crc_low_q, crc_low_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] cmd_q, cmd_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_next;
  logic        hunt;

  assign crc_next = crc_arc_byte(crc_q, byte_i);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    body_d      = body_q;
    crc_pos_d   = crc_pos_q;
    crc_low_d   = crc_low_q;
    crc_d       = crc_q;
    ver_d       = ver_q;
    flags_d     = flags_q;
    cmd_d       = cmd_q;
    seq_d       = seq_q;
    len_d       = len_q;
    hunt        = 1'b0;
    res_valid_o = 1'b0;
    res_o.status    = ST_BODY;
    res_o.data_byte = 8'h00;
    if (step_i) begin
      case (phase_q)
        PH_SYNC1: begin
          if (byte_i == cfg_i.sync_first) begin
            phase_d = PH_SYNC2;
          end else begin
            res_valid_o  = 1'b1;
            res_o.status = ST_SYNC_MISS;
          end
        end
        PH_SYNC2: begin
          if (byte_i == cfg_i.sync_second) begin
            phase_d = PH_HEADER;
            pos_d   = 3'd0;
            crc_d   = CRC_INIT;
          end else if (byte_i != cfg_i.sync_first) begin
            hunt         = 1'b1;
            res_valid_o  = 1'b1;
            res_o.status = ST_SYNC_MISS;
          end
        end
        PH_HEADER: begin
          case (pos_q)
            3'd0:    ver_d   = byte_i;
            3'd1:    flags_d = byte_i;
            3'd2:    cmd_d   = {8'h00, byte_i};
            3'd3:    cmd_d   = {byte_i, cmd_q[7:0]};
            3'd4:    seq_d   = byte_i;
            default: len_d   = byte_i;
          endcase
          crc_d = crc_next;
          pos_d = pos_q + 3'd1;
          if (pos_d >= 3'd6) begin
            if (ver_d != cfg_i.protocol_version) begin
              hunt         = 1'b1;
              res_valid_o  = 1'b1;
              res_o.status = ST_BAD_VER;
            end else if (len_d > cfg_i.max_payload) begin
              hunt         = 1'b1;
              res_valid_o  = 1'b1;
              res_o.status = ST_LEN_OVF;
            end else begin
              body_d    = 8'd0;
              crc_pos_d = 1'b0;
              phase_d   = (len_d == 8'd0) ? PH_CRC : PH_BODY;
            end
          end
        end
        PH_BODY: begin
          crc_d           = crc_next;
          body_d          = body_q + 8'd1;
          res_valid_o     = 1'b1;
          res_o.status    = ST_BODY;
          res_o.data_byte = byte_i;
          if (body_d >= len_q) begin
            phase_d   = PH_CRC;
            crc_pos_d = 1'b0;
          end
        end
        PH_CRC: begin
          if (!crc_pos_q) begin
            crc_low_d = byte_i;
            crc_pos_d = 1'b1;
          end else begin
            hunt         = 1'b1;
            res_valid_o  = 1'b1;
            res_o.status = ({byte_i, crc_low_q} == crc_q) ? ST_OK : ST_CRC_FAIL;
          end
        end
        default: hunt = 1'b1;
      endcase
    end
    res_o.frame_flags = flags_d;
    res_o.frame_cmd   = cmd_d;
    res_o.frame_seq   = seq_d;
    res_o.frame_len   = len_d;
    if (hunt) begin
      phase_d   = PH_SYNC1;
      pos_d     = 3'd0;
      body_d    = 8'd0;
      crc_pos_d = 1'b0;
      crc_low_d = 8'd0;
      crc_d     = CRC_INIT;
      ver_d     = 8'd0;
      flags_d   = 8'd0;
      cmd_d     = 16'd0;
      seq_d     = 8'd0;
      len_d     = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SYNC1;
      pos_q     <= 3'd0;
      body_q    <= 8'd0;
      crc_pos_q <= 1'b0;
      crc_low_q <= 8'd0;
      crc_q     <= CRC_INIT;
      ver_q     <= 8'd0;
      flags_q   <= 8'd0;
      cmd_q     <= 16'd0;
      seq_q     <= 8'd0;
      len_q     <= 8'd0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      body_q    <= body_d;
      crc_pos_q <= crc_pos_d;
      crc_low_q <= crc_low_d;
      crc_q     <= crc_d;
      ver_q     <= ver_d;
      flags_q   <= flags_d;
      cmd_q     <= cmd_d;
      seq_q     <= seq_d;
      len_q     <= len_d;
    end
  end

endmodule

### hdl/framed_packet_receiver_crc16.sv
// Top level of the framed packet receiver: APB register file, input stage, result stage.
// Depends on frp_pkg, frp_parser and assert_macros.svh.
//
// Usage:
//   Input channel: rx_byte_i with in_valid_i / in_stall_o, one byte per transaction.
//   Output channel: status_o, data_byte_o and the frame_* fields with
//   out_valid_o / out_stall_i; zero or one result transaction per input byte.
//   A byte is captured in the input register, stepped through the parser once
//   the result stage is free, and its result is loaded into the result register
//   as it is stepped.
//   Throughput is one byte per cycle while out_stall_i holds no pending result;
//   the parser's combinational CRC byte update and state step set that figure.
//   When out_stall_i holds a pending result, the input register keeps one byte
//   and in_stall_o rises only while that byte cannot be stepped.
//   Reset returns the parser to the sync hunt, clears both stages and loads the
//   register defaults: sync 0xAA then 0x55, version 1, max body length 64.
//   Registers sit at byte addresses 0, 4, 8, 12; write them only while idle.
module framed_packet_receiver_crc16 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [frp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [7:0]                   data_byte_o,
  output logic [7:0]                   frame_flags_o,
  output logic [15:0]                  frame_cmd_o,
  output logic [7:0]                   frame_seq_o,
  output logic [7:0]                   frame_len_o
);
  import frp_pkg::*;
  `include "assert_macros.svh"

  cfg_t     cfg_q, cfg_d;
  logic     cfg_wr;
  reg_idx_e reg_idx;

  logic     s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic     out_valid_q, out_valid_d;
  result_t  out_res_q;
  logic     out_free, step, in_accept;
  logic     res_valid;
  result_t  res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d  = cfg_q;
    prdata = 32'd0;
    case (reg_idx)
      REG_SYNC_FIRST: begin
        prdata = {24'd0, cfg_q.sync_first};
        if (cfg_wr) cfg_d.sync_first = pwdata[7:0];
      end
      REG_SYNC_SECOND: begin
        prdata = {24'd0, cfg_q.sync_second};
        if (cfg_wr) cfg_d.sync_second = pwdata[7:0];
      end
      REG_VERSION: begin
        prdata = {24'd0, cfg_q.protocol_version};
        if (cfg_wr) cfg_d.protocol_version = pwdata[7:0];
      end
      REG_MAX_PAYLOAD: begin
        prdata = {24'd0, cfg_q.max_payload};
        if (cfg_wr) cfg_d.max_payload = pwdata[7:0];
      end
      default: prdata = 32'd0;
    endcase
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step && res_valid;
    end
  end

  frp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s1_byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first       <= RST_SYNC_FIRST;
      cfg_q.sync_second      <= RST_SYNC_SECOND;
      cfg_q.protocol_version <= RST_VERSION;
      cfg_q.max_payload      <= RST_MAX_PAYLOAD;
      s1_valid_q             <= 1'b0;
      out_valid_q            <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= rx_byte_i;
    end
    if (step && res_valid && out_free) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_res_q.status;
  assign data_byte_o   = out_res_q.data_byte;
  assign frame_flags_o = out_res_q.frame_flags;
  assign frame_cmd_o   = out_res_q.frame_cmd;
  assign frame_seq_o   = out_res_q.frame_seq;
  assign frame_len_o   = out_res_q.frame_len;

  `ASSERT_NEVER(a_stall_needs_item, clk_i, rst_ni, in_stall_o && !s1_valid_q, "stall without held byte")
  `ASSERT_PROP(a_data_only_body, clk_i, rst_ni, (out_valid_o && status_o != ST_BODY) |-> (data_byte_o == 8'd0), "data on non-body result")
  `ASSERT_PROP(a_sync_miss_clean, clk_i, rst_ni, (out_valid_o && status_o == ST_SYNC_MISS) |-> (frame_flags_o == 8'd0 && frame_cmd_o == 16'd0 && frame_seq_o == 8'd0 && frame_len_o == 8'd0), "sync miss carries header")

endmodule

### test/framed_packet_receiver_crc16_tb.sv
// Self-checking testbench for framed_packet_receiver_crc16: directed and random byte
// streams under several register settings, with a predicting scoreboard class.
// Depends on frp_pkg and the receiver RTL.
module framed_packet_receiver_crc16_tb;
  import frp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_WAIT  = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BYTES  = 85;

  typedef enum logic [2:0] {
    HUNT_FIRST  = 3'd0,
    HUNT_SECOND = 3'd1,
    IN_HEADER   = 3'd2,
    IN_BODY     = 3'd3,
    IN_CRC      = 3'd4
  } parse_e;

  class frame_scoreboard;
    cfg_t        cfg;
    parse_e      stage;
    logic [2:0]  hdr_pos;
    logic [7:0]  body_cnt;
    logic        crc_hi_next;
    logic [7:0]  crc_lo;
    logic [15:0] crc_acc;
    logic [7:0]  ver;
    logic [7:0]  flags;
    logic [15:0] cmd;
    logic [7:0]  seq;
    logic [7:0]  len;
    result_t     expected_q[$];
    int          failures;
    int          bytes_in;
    int          results_checked;
    int          by_status[6];

    function new();
      cfg = {RST_SYNC_FIRST, RST_SYNC_SECOND, RST_VERSION, RST_MAX_PAYLOAD};
      failures = 0;
      bytes_in = 0;
      results_checked = 0;
      foreach (by_status[i]) by_status[i] = 0;
      hunt();
    endfunction

    static function logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void hunt();
      stage = HUNT_FIRST;
      hdr_pos = '0;
      body_cnt = '0;
      crc_hi_next = 1'b0;
      crc_lo = '0;
      crc_acc = CRC_INIT;
      ver = '0;
      flags = '0;
      cmd = '0;
      seq = '0;
      len = '0;
    endfunction

    function result_t outcome(input status_e s, input logic [7:0] d);
      result_t r;
      r.status = s;
      r.data_byte = d;
      r.frame_flags = flags;
      r.frame_cmd = cmd;
      r.frame_seq = seq;
      r.frame_len = len;
      return r;
    endfunction

    function void set_reg(input reg_idx_e idx, input logic [7:0] v);
      case (idx)
        REG_SYNC_FIRST:  cfg.sync_first = v;
        REG_SYNC_SECOND: cfg.sync_second = v;
        REG_VERSION:     cfg.protocol_version = v;
        REG_MAX_PAYLOAD: cfg.max_payload = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(input logic [7:0] b);
      logic [15:0] got_crc;
      bytes_in++;
      case (stage)
        HUNT_FIRST: begin
          if (b == cfg.sync_first) stage = HUNT_SECOND;
          else expected_q.push_back(outcome(ST_SYNC_MISS, 8'h00));
        end
        HUNT_SECOND: begin
          if (b == cfg.sync_second) begin
            stage = IN_HEADER;
            hdr_pos = '0;
            crc_acc = CRC_INIT;
          end else if (b != cfg.sync_first) begin
            hunt();
            expected_q.push_back(outcome(ST_SYNC_MISS, 8'h00));
          end
        end
        IN_HEADER: begin
          case (hdr_pos)
            3'd0: ver = b;
            3'd1: flags = b;
            3'd2: cmd = {8'h00, b};
            3'd3: cmd[15:8] = b;
            3'd4: seq = b;
            default: len = b;
          endcase
          crc_acc = crc_fold(crc_acc, b);
          hdr_pos = hdr_pos + 3'd1;
          if (hdr_pos >= 3'd6) begin
            if (ver != cfg.protocol_version) begin
              expected_q.push_back(outcome(ST_BAD_VER, 8'h00));
              hunt();
            end else if (len > cfg.max_payload) begin
              expected_q.push_back(outcome(ST_LEN_OVF, 8'h00));
              hunt();
            end else begin
              body_cnt = '0;
              crc_hi_next = 1'b0;
              stage = (len == 8'd0) ? IN_CRC : IN_BODY;
            end
          end
        end
        IN_BODY: begin
          crc_acc = crc_fold(crc_acc, b);
          body_cnt = body_cnt + 8'd1;
          expected_q.push_back(outcome(ST_BODY, b));
          if (body_cnt >= len) begin
            stage = IN_CRC;
            crc_hi_next = 1'b0;
          end
        end
        IN_CRC: begin
          if (!crc_hi_next) begin
            crc_lo = b;
            crc_hi_next = 1'b1;
          end else begin
            got_crc = {b, crc_lo};
            expected_q.push_back(outcome((got_crc == crc_acc) ? ST_OK : ST_CRC_FAIL, 8'h00));
            hunt();
          end
        end
        default: hunt();
      endcase
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d data %h", got.status, got.data_byte);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      by_status[want.status]++;
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.data_byte != want.data_byte) begin
        $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
        failures++;
      end
      if (got.frame_flags != want.frame_flags) begin
        $error("frame_flags: expected %h, got %h", want.frame_flags, got.frame_flags);
        failures++;
      end
      if (got.frame_cmd != want.frame_cmd) begin
        $error("frame_cmd: expected %h, got %h", want.frame_cmd, got.frame_cmd);
        failures++;
      end
      if (got.frame_seq != want.frame_seq) begin
        $error("frame_seq: expected %h, got %h", want.frame_seq, got.frame_seq);
        failures++;
      end
      if (got.frame_len != want.frame_len) begin
        $error("frame_len: expected %h, got %h", want.frame_len, got.frame_len);
        failures++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          status_o;
  logic [7:0]          data_byte_o;
  logic [7:0]          frame_flags_o;
  logic [15:0]         frame_cmd_o;
  logic [7:0]          frame_seq_o;
  logic [7:0]          frame_len_o;

  frame_scoreboard sb;
  int   cycle_count = 0;
  int   send_gap_pct = 0;
  int   stall_pct = 0;
  int   frames_sent = 0;
  int   hold_left = 0;
  logic hold_token = 1'b0;
  logic hold_seen = 1'b0;

  framed_packet_receiver_crc16 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .data_byte_o   (data_byte_o),
    .frame_flags_o (frame_flags_o),
    .frame_cmd_o   (frame_cmd_o),
    .frame_seq_o   (frame_seq_o),
    .frame_len_o   (frame_len_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(result_t'({status_o, data_byte_o, frame_flags_o, frame_cmd_o,
                                   frame_seq_o, frame_len_o}));
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b);
  endtask

  task automatic send_packet(input int extra_sync, input logic [7:0] ver,
                             input logic [7:0] flg, input logic [15:0] cmd,
                             input logic [7:0] seq, input logic [7:0] len, input bit crc_ok);
    logic [7:0]  hdr[6];
    logic [7:0]  b;
    logic [15:0] crc;
    crc = CRC_INIT;
    hdr = '{ver, flg, cmd[7:0], cmd[15:8], seq, len};
    repeat (extra_sync) send_byte(sb.cfg.sync_first);
    send_byte(sb.cfg.sync_first);
    send_byte(sb.cfg.sync_second);
    foreach (hdr[i]) begin
      send_byte(hdr[i]);
      crc = frame_scoreboard::crc_fold(crc, hdr[i]);
    end
    frames_sent++;
    if (ver == sb.cfg.protocol_version && len <= sb.cfg.max_payload) begin
      repeat (len) begin
        b = 8'($urandom);
        send_byte(b);
        crc = frame_scoreboard::crc_fold(crc, b);
      end
      if (!crc_ok) crc ^= 16'(1) << $urandom_range(0, 15);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
    end
  endtask

  task automatic send_random();
    int         kind;
    int         reps;
    int         len;
    int         top;
    logic [7:0] ver;
    kind = $urandom_range(0, 9);
    top = int'(sb.cfg.max_payload);
    if (kind == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else if (kind == 1) begin
      send_byte(sb.cfg.sync_first);
      repeat ($urandom_range(0, 7)) send_byte(8'($urandom));
    end else begin
      reps = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      ver = ($urandom_range(0, 7) == 0) ? 8'($urandom) : sb.cfg.protocol_version;
      case ($urandom_range(0, 15))
        0: len = top;
        1: len = (top < 255) ? $urandom_range(top + 1, 255) : 255;
        2: len = $urandom_range(0, top);
        default: len = $urandom_range(0, (top < 10) ? top : 10);
      endcase
      send_packet(reps, ver, 8'($urandom), 16'($urandom), 8'($urandom), 8'(len),
                  $urandom_range(0, 5) != 0);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
  endtask

  task automatic run_phase(input cfg_t c, input int gap, input int stall, input bit hold);
    int start;
    settle();
    write_reg(REG_SYNC_FIRST, c.sync_first);
    write_reg(REG_SYNC_SECOND, c.sync_second);
    write_reg(REG_VERSION, c.protocol_version);
    write_reg(REG_MAX_PAYLOAD, c.max_payload);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    send_gap_pct = gap;
    stall_pct <= stall;
    if (hold) hold_token <= ~hold_token;
    @(posedge clk_i);
    start = sb.bytes_in;
    while (sb.bytes_in - start < PHASE_BYTES) send_random();
  endtask

  initial begin
    int start;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sync misses at both byte extremes, then a miss on the second sync byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(RST_SYNC_FIRST);
    send_byte(8'h00);
    // repeated first sync byte, then a good one-byte frame
    send_packet(1, RST_VERSION, 8'hFF, 16'hFF00, 8'h80, 8'd1, 1'b1);
    // bad version together with a length overflow
    send_packet(0, 8'h00, 8'h00, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    // empty body with a corrupted checksum
    send_packet(0, RST_VERSION, 8'h5A, 16'h0001, 8'h00, 8'd0, 1'b0);
    // length just above the limit
    send_packet(0, RST_VERSION, 8'h01, 16'h8000, 8'h7F, RST_MAX_PAYLOAD + 8'd1, 1'b1);

    start = sb.bytes_in;
    while (sb.bytes_in - start < PHASE_BYTES) send_random();

    run_phase({8'h00, 8'hFF, 8'h00, 8'h00}, 79, 0, 1'b0);
    run_phase({8'hFF, 8'h00, 8'hFF, 8'hFF}, 0, 79, 1'b0);
    run_phase({8'h3C, 8'h3C, 8'h7F, 8'h10}, 11, 11, 1'b0);
    run_phase({8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 40))},
              0, 0, 1'b1);
    run_phase({RST_SYNC_FIRST, RST_SYNC_SECOND, RST_VERSION, RST_MAX_PAYLOAD}, 11, 11, 1'b0);
    settle();

    $display("Streamed %0d bytes (%0d framed packets) over six register settings; %0d results.",
             sb.bytes_in, frames_sent, sb.results_checked);
    $display("Outcomes: body %0d, accepted %0d, crc fail %0d, bad version %0d, overflow %0d, miss %0d",
             sb.by_status[ST_BODY], sb.by_status[ST_OK], sb.by_status[ST_CRC_FAIL],
             sb.by_status[ST_BAD_VER], sb.by_status[ST_LEN_OVF], sb.by_status[ST_SYNC_MISS]);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### framed_packet_receiver_crc16.f
+incdir+hdl
hdl/frp_pkg.sv
hdl/frp_parser.sv
hdl/framed_packet_receiver_crc16.sv
test/framed_packet_receiver_crc16_tb.sv
